// File: rtl/v3alu_pkg.sv
// Shared types, constants and helpers of the Q16.16 vector ALU.
`timescale 1ns / 1ps
package v3alu_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int PROD_W        = 64;
  localparam int SUM_W         = 66;
  localparam int NPROD         = 9;
  localparam int SQ_STEPS      = 32;
  localparam int REM_W         = 35;
  localparam int IN_TDATA_W    = 232;
  localparam int OUT_TDATA_W   = 136;

  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

  // Operation codes
  typedef enum logic [3:0] {
    FN_ADD  = 4'd0,
    FN_SUB  = 4'd1,
    FN_SCL  = 4'd2,
    FN_HAD  = 4'd3,
    FN_DOT  = 4'd4,
    FN_WDG  = 4'd5,
    FN_CRS  = 4'd6,
    FN_NRM  = 4'd7,
    FN_GEO  = 4'd8
  } func_t;

  // Product slots: 0..2 diagonal (a_i times b_i, s or a_i), 3..8 cross terms
  localparam int P_XX = 0;
  localparam int P_YY = 1;
  localparam int P_ZZ = 2;
  localparam int P_XY = 3;
  localparam int P_YX = 4;
  localparam int P_XZ = 5;
  localparam int P_ZX = 6;
  localparam int P_YZ = 7;
  localparam int P_ZY = 8;

  typedef struct packed {
    logic ovf;
    logic signed [DATA_W-1:0] val;
  } sat_t;

  // Stage 1 payload: raw products and add/sub results
  typedef struct packed {
    func_t func;
    logic signed [NPROD-1:0][PROD_W-1:0] prod;
    logic signed [2:0][DATA_W:0] addsub;
  } mul_t;

  // Stage 2 payload: truncated products and sum of squares
  typedef struct packed {
    func_t func;
    logic signed [NPROD-1:0][PROD_W-1:0] tp;
    logic [PROD_W-1:0] sq_sum;
    logic signed [2:0][DATA_W:0] addsub;
  } trc_t;

  // Result payload carried through the root pipeline
  typedef struct packed {
    logic signed [DATA_W-1:0] rx;
    logic signed [DATA_W-1:0] ry;
    logic signed [DATA_W-1:0] rz;
    logic signed [DATA_W-1:0] sc;
    logic ovf;
    logic is_norm;
    logic [PROD_W-1:0] rad;
    logic [REM_W-1:0] rem;
    logic [DATA_W-1:0] root;
  } res_t;

  // Clamp a wide signed value to 32 bits
  function automatic sat_t sat32(input logic signed [SUM_W-1:0] v);
    sat_t r;
    if (v > SUM_W'(S32_MAX)) begin
      r.ovf = 1'b1;
      r.val = S32_MAX;
    end else if (v < SUM_W'(S32_MIN)) begin
      r.ovf = 1'b1;
      r.val = S32_MIN;
    end else begin
      r.ovf = 1'b0;
      r.val = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/vec3_fixed_point_alu_unit.sv
// Top level of the three-component signed fixed-point vector ALU.
// One item in, one item out: a multiply stage (nine 32x32 multipliers), a
// truncate stage, a sum and saturate stage, and 32 stages of the square root
// (two radicand bits each), which every item passes so that results leave in
// order. A new item is taken in every cycle unless all stages are full and
// the output waits; each stage moves on when its successor is empty or
// moving, so bubbles are squeezed out while the output waits. Products are
// rounded toward zero to FRAC_BITS fraction bits, all returned values
// saturate to 32 bits and the overflow bit reports any clamp.
`timescale 1ns / 1ps
module vec3_fixed_point_alu_unit #(
  parameter int FRAC_BITS = v3alu_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // func[3:0], a_x, a_y, a_z, b_x, b_y, b_z, scale_factor (32 each), zero pad
  input  logic [v3alu_pkg::IN_TDATA_W-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // r_x, r_y, r_z, scalar_out (32 each), overflow, zero pad
  output logic [v3alu_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import v3alu_pkg::*;

  logic mul_valid, mul_ready, cmb_valid, cmb_ready;
  mul_t mul_data;
  res_t cmb_data, fin;
  logic signed [DATA_W-1:0] scalar_out;
  logic overflow;

  v3alu_mul u_mul (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .func         (func_t'(s_tdata[3:0])),
    .a_x          (s_tdata[35:4]),
    .a_y          (s_tdata[67:36]),
    .a_z          (s_tdata[99:68]),
    .b_x          (s_tdata[131:100]),
    .b_y          (s_tdata[163:132]),
    .b_z          (s_tdata[195:164]),
    .scale_factor (s_tdata[227:196]),
    .out_valid    (mul_valid),
    .out_ready    (mul_ready),
    .out_data     (mul_data)
  );

  v3alu_combine #(.FRAC_BITS(FRAC_BITS)) u_combine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_valid),
    .in_ready  (mul_ready),
    .in_data   (mul_data),
    .out_valid (cmb_valid),
    .out_ready (cmb_ready),
    .out_data  (cmb_data)
  );

  v3alu_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmb_valid),
    .in_ready  (cmb_ready),
    .in_data   (cmb_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (fin)
  );

  // Norm takes the clamped root as its scalar
  always_comb begin
    scalar_out = fin.sc;
    overflow   = fin.ovf;
    if (fin.is_norm) begin
      scalar_out = fin.root[DATA_W-1] ? S32_MAX : $signed(fin.root);
      overflow   = fin.ovf | fin.root[DATA_W-1];
    end
  end

  assign m_tdata = {7'd0, overflow, scalar_out, fin.rz, fin.ry, fin.rx};

  // Input is held back only while the output is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without output backpressure");

  // A set overflow bit comes with at least one clamped value
  a_ovf_clamped: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[128]) |->
      (m_tdata[31:0] == 32'h7fff_ffff || m_tdata[31:0] == 32'h8000_0000 ||
       m_tdata[63:32] == 32'h7fff_ffff || m_tdata[63:32] == 32'h8000_0000 ||
       m_tdata[95:64] == 32'h7fff_ffff || m_tdata[95:64] == 32'h8000_0000 ||
       m_tdata[127:96] == 32'h7fff_ffff || m_tdata[127:96] == 32'h8000_0000))
    else $error("overflow without clamped value");

  // A norm result carries no vector part
  a_norm_vec_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && fin.is_norm) |-> (m_tdata[95:0] == 96'd0))
    else $error("norm result with nonzero vector part");

endmodule

// File: rtl/v3alu_mul.sv
// Operand selection, nine 32x32 multipliers and add/sub, one register stage.
`timescale 1ns / 1ps
module v3alu_mul (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  v3alu_pkg::func_t func,
  input  logic signed [31:0] a_x,
  input  logic signed [31:0] a_y,
  input  logic signed [31:0] a_z,
  input  logic signed [31:0] b_x,
  input  logic signed [31:0] b_y,
  input  logic signed [31:0] b_z,
  input  logic signed [31:0] scale_factor,
  output logic out_valid,
  input  logic out_ready,
  output v3alu_pkg::mul_t out_data
);
  import v3alu_pkg::*;

  logic signed [DATA_W-1:0] dx, dy, dz;
  mul_t nxt;

  assign in_ready = !out_valid || out_ready;

  // Second operand of the diagonal products
  always_comb begin
    case (func)
      FN_SCL: begin
        dx = scale_factor;
        dy = scale_factor;
        dz = scale_factor;
      end
      FN_NRM: begin
        dx = a_x;
        dy = a_y;
        dz = a_z;
      end
      default: begin
        dx = b_x;
        dy = b_y;
        dz = b_z;
      end
    endcase
  end

  always_comb begin
    nxt.func        = func;
    nxt.prod[P_XX]  = PROD_W'(a_x) * PROD_W'(dx);
    nxt.prod[P_YY]  = PROD_W'(a_y) * PROD_W'(dy);
    nxt.prod[P_ZZ]  = PROD_W'(a_z) * PROD_W'(dz);
    nxt.prod[P_XY]  = PROD_W'(a_x) * PROD_W'(b_y);
    nxt.prod[P_YX]  = PROD_W'(a_y) * PROD_W'(b_x);
    nxt.prod[P_XZ]  = PROD_W'(a_x) * PROD_W'(b_z);
    nxt.prod[P_ZX]  = PROD_W'(a_z) * PROD_W'(b_x);
    nxt.prod[P_YZ]  = PROD_W'(a_y) * PROD_W'(b_z);
    nxt.prod[P_ZY]  = PROD_W'(a_z) * PROD_W'(b_y);
    if (func == FN_SUB) begin
      nxt.addsub[0] = (DATA_W+1)'(a_x) - (DATA_W+1)'(b_x);
      nxt.addsub[1] = (DATA_W+1)'(a_y) - (DATA_W+1)'(b_y);
      nxt.addsub[2] = (DATA_W+1)'(a_z) - (DATA_W+1)'(b_z);
    end else begin
      nxt.addsub[0] = (DATA_W+1)'(a_x) + (DATA_W+1)'(b_x);
      nxt.addsub[1] = (DATA_W+1)'(a_y) + (DATA_W+1)'(b_y);
      nxt.addsub[2] = (DATA_W+1)'(a_z) + (DATA_W+1)'(b_z);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= nxt;
    end
  end

endmodule

// File: rtl/v3alu_combine.sv
// Truncation toward zero, then sums, operation select and saturation.
`timescale 1ns / 1ps
module v3alu_combine #(
  parameter int FRAC_BITS = v3alu_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  v3alu_pkg::mul_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output v3alu_pkg::res_t out_data
);
  import v3alu_pkg::*;

  trc_t trc, trc_next;
  logic trc_valid, trc_ready;
  res_t res_next;

  function automatic logic signed [PROD_W-1:0] trunc0(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] sh;
    mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
    sh  = mag >> FRAC_BITS;
    return p[PROD_W-1] ? -$signed(sh) : $signed(sh);
  endfunction

  function automatic logic signed [SUM_W-1:0] ext(input logic signed [PROD_W-1:0] p);
    return SUM_W'(p);
  endfunction

  assign trc_ready = !out_valid || out_ready;
  assign in_ready  = !trc_valid || trc_ready;

  // Stage 2: truncate products, sum the raw squares for the norm
  always_comb begin
    trc_next.func   = in_data.func;
    trc_next.addsub = in_data.addsub;
    for (int i = 0; i < NPROD; i++) begin
      trc_next.tp[i] = trunc0(in_data.prod[i]);
    end
    trc_next.sq_sum = PROD_W'(in_data.prod[P_XX]) + PROD_W'(in_data.prod[P_YY])
                    + PROD_W'(in_data.prod[P_ZZ]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trc_valid <= 1'b0;
    end else if (in_ready) begin
      trc_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      trc <= trc_next;
    end
  end

  // Stage 3: form the operation's values and clamp them
  logic signed [SUM_W-1:0] dot, w12, w13, w23;
  logic signed [SUM_W-1:0] vx, vy, vz, vs;
  sat_t sx, sy, sz, ss;
  logic nrm;

  always_comb begin
    dot = ext(trc.tp[P_XX]) + ext(trc.tp[P_YY]) + ext(trc.tp[P_ZZ]);
    w12 = ext(trc.tp[P_XY]) - ext(trc.tp[P_YX]);
    w13 = ext(trc.tp[P_XZ]) - ext(trc.tp[P_ZX]);
    w23 = ext(trc.tp[P_YZ]) - ext(trc.tp[P_ZY]);
    vx  = '0;
    vy  = '0;
    vz  = '0;
    vs  = '0;
    nrm = 1'b0;
    case (trc.func)
      FN_ADD, FN_SUB: begin
        // Sign-extend the 33-bit sums
        vx = SUM_W'($signed(trc.addsub[0]));
        vy = SUM_W'($signed(trc.addsub[1]));
        vz = SUM_W'($signed(trc.addsub[2]));
      end
      FN_SCL, FN_HAD: begin
        vx = ext(trc.tp[P_XX]);
        vy = ext(trc.tp[P_YY]);
        vz = ext(trc.tp[P_ZZ]);
      end
      FN_DOT: vs = dot;
      FN_WDG: begin
        vx = w12;
        vy = w13;
        vz = w23;
      end
      FN_GEO: begin
        vx = w12;
        vy = w13;
        vz = w23;
        vs = dot;
      end
      FN_CRS: begin
        vx = w23;
        vy = -w13;
        vz = w12;
      end
      FN_NRM: nrm = 1'b1;
      default: ;
    endcase
    sx = sat32(vx);
    sy = sat32(vy);
    sz = sat32(vz);
    ss = sat32(vs);
    res_next.rx      = sx.val;
    res_next.ry      = sy.val;
    res_next.rz      = sz.val;
    res_next.sc      = ss.val;
    res_next.ovf     = sx.ovf | sy.ovf | sz.ovf | ss.ovf;
    res_next.is_norm = nrm;
    res_next.rad     = trc.sq_sum;
    res_next.rem     = '0;
    res_next.root    = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (trc_ready) begin
      out_valid <= trc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (trc_ready && trc_valid) begin
      out_data <= res_next;
    end
  end

endmodule

// File: rtl/v3alu_sqrt.sv
// Pipelined integer square root, two radicand bits per stage, payload alongside.
`timescale 1ns / 1ps
module v3alu_sqrt (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  v3alu_pkg::res_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output v3alu_pkg::res_t out_data
);
  import v3alu_pkg::*;

  res_t q [SQ_STEPS];
  logic vld [SQ_STEPS];
  logic rdy [SQ_STEPS+1];

  // One restoring step of the digit-by-digit root
  function automatic res_t sq_step(input res_t d);
    res_t r;
    logic [REM_W-1:0] rs;
    logic [REM_W-1:0] trial;
    r     = d;
    rs    = {d.rem[REM_W-3:0], d.rad[PROD_W-1 -: 2]};
    trial = {1'b0, d.root, 2'b01};
    r.rad = {d.rad[PROD_W-3:0], 2'b00};
    if (rs >= trial) begin
      r.rem  = rs - trial;
      r.root = {d.root[DATA_W-2:0], 1'b1};
    end else begin
      r.rem  = rs;
      r.root = {d.root[DATA_W-2:0], 1'b0};
    end
    return r;
  endfunction

  assign rdy[SQ_STEPS] = out_ready;
  assign in_ready      = rdy[0];
  assign out_valid     = vld[SQ_STEPS-1];
  assign out_data      = q[SQ_STEPS-1];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_stage
    res_t src;
    logic src_v;
    if (k == 0) begin : g_first
      assign src   = in_data;
      assign src_v = in_valid;
    end else begin : g_rest
      assign src   = q[k-1];
      assign src_v = vld[k-1];
    end

    assign rdy[k] = !vld[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && src_v) begin
        q[k] <= sq_step(src);
      end
    end
  end

endmodule

// File: verif/testbench.sv
// Testbench of the Q16.16 vector ALU: directed and random items checked against a predictor.
`timescale 1ns / 1ps
module testbench;
  import v3alu_pkg::*;

  localparam int LATENCY = 35;

  // Expected result of one item
  typedef struct packed {
    logic [31:0] rx;
    logic [31:0] ry;
    logic [31:0] rz;
    logic [31:0] sc;
    logic ovf;
  } alu_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  logic [IN_TDATA_W-1:0] pending_items[$];
  alu_res_t expected_results[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  bit stim_done = 1'b0;

  vec3_fixed_point_alu_unit u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Product truncated toward zero
  function automatic longint trunc_mul(longint p, longint q);
    longint full;
    full = p * q;
    if (full < 0) return -((-full) >>> FRAC_BITS_DEF);
    return full >>> FRAC_BITS_DEF;
  endfunction

  function automatic logic [31:0] clamp32(longint v, ref logic ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 32'h7fff_ffff;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Predict the result of one packed item
  function automatic alu_res_t predict_alu(logic [IN_TDATA_W-1:0] d);
    longint a[3], b[3], v[3], s, sc, w0, w1, w2;
    longint unsigned sum, r;
    logic [3:0] fn;
    logic ovf;
    alu_res_t res;
    fn = d[3:0];
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'($signed(d[4+32*i +: 32]));
      b[i] = longint'($signed(d[100+32*i +: 32]));
      v[i] = 0;
    end
    s = longint'($signed(d[196 +: 32]));
    sc = 0;
    ovf = 1'b0;
    w0 = trunc_mul(a[0], b[1]) - trunc_mul(a[1], b[0]);
    w1 = trunc_mul(a[0], b[2]) - trunc_mul(a[2], b[0]);
    w2 = trunc_mul(a[1], b[2]) - trunc_mul(a[2], b[1]);
    case (fn)
      FN_ADD: for (int i = 0; i < 3; i++) v[i] = a[i] + b[i];
      FN_SUB: for (int i = 0; i < 3; i++) v[i] = a[i] - b[i];
      FN_SCL: for (int i = 0; i < 3; i++) v[i] = trunc_mul(a[i], s);
      FN_HAD: for (int i = 0; i < 3; i++) v[i] = trunc_mul(a[i], b[i]);
      FN_DOT: sc = trunc_mul(a[0], b[0]) + trunc_mul(a[1], b[1]) + trunc_mul(a[2], b[2]);
      FN_WDG, FN_GEO: begin
        v[0] = w0;
        v[1] = w1;
        v[2] = w2;
        if (fn == FN_GEO)
          sc = trunc_mul(a[0], b[0]) + trunc_mul(a[1], b[1]) + trunc_mul(a[2], b[2]);
      end
      FN_CRS: begin
        v[0] = w2;
        v[1] = -w1;
        v[2] = w0;
      end
      FN_NRM: begin
        sum = 0;
        for (int i = 0; i < 3; i++) sum += longint'(a[i] * a[i]);
        r = int_sqrt(sum);
        if (r > 64'd2147483647) begin
          ovf = 1'b1;
          r = 64'd2147483647;
        end
        sc = longint'(r);
      end
      default: ;
    endcase
    res.rx = clamp32(v[0], ovf);
    res.ry = clamp32(v[1], ovf);
    res.rz = clamp32(v[2], ovf);
    res.sc = clamp32(sc, ovf);
    res.ovf = ovf;
    return res;
  endfunction

  function automatic logic [31:0] pick_component();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'h0001_0000;
      4: return 32'(int'($urandom_range(0, 65535)) - 32768);
      5: return 32'(int'($urandom_range(0, 33554431)) - 16777216);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_item(logic [3:0] fn, logic [31:0] c[7]);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[3:0] = fn;
    for (int i = 0; i < 7; i++) d[4+32*i +: 32] = c[i];
    return d;
  endfunction

  // Driver: offer items from the queue, idling at random
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_tdata <= pending_items.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Predict on acceptance
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) expected_results.push_back(predict_alu(s_tdata));
  end

  // Receiver ready, with random stalls and a long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    alu_res_t got, exp_r;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[127:96], m_tdata[128]};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got.rx !== exp_r.rx) begin
          $display("%0t: r_x expected %h actual %h", $time, exp_r.rx, got.rx);
          errors++;
        end
        if (got.ry !== exp_r.ry) begin
          $display("%0t: r_y expected %h actual %h", $time, exp_r.ry, got.ry);
          errors++;
        end
        if (got.rz !== exp_r.rz) begin
          $display("%0t: r_z expected %h actual %h", $time, exp_r.rz, got.rz);
          errors++;
        end
        if (got.sc !== exp_r.sc) begin
          $display("%0t: scalar_out expected %h actual %h", $time, exp_r.sc, got.sc);
          errors++;
        end
        if (got.ovf !== exp_r.ovf) begin
          $display("%0t: overflow expected %b actual %b", $time, exp_r.ovf, got.ovf);
          errors++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic [31:0] c[7];
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // Directed: every code with extremes, and unused codes
    for (int f = 0; f < 16; f++) begin
      for (int i = 0; i < 7; i++) c[i] = (f % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
      if (f == 4) c[3] = 32'h8000_0000;
      pending_items.push_back(pack_item(4'(f), c));
    end
    for (int i = 0; i < 7; i++) c[i] = 32'hffff_ffff;
    pending_items.push_back(pack_item(FN_SCL, c));
    for (int i = 0; i < 7; i++) c[i] = 32'h0001_8000;
    pending_items.push_back(pack_item(FN_CRS, c));
    pending_items.push_back(pack_item(FN_NRM, c));
    c = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
    pending_items.push_back(pack_item(FN_NRM, c));
    c = '{32'hffff_0000, 32'h0002_0000, 32'h0, 32'h0003_0000, 32'hfffe_8000, 32'h1, 32'h0};
    pending_items.push_back(pack_item(FN_GEO, c));
    pending_items.push_back(pack_item(FN_DOT, c));
    pending_items.push_back(pack_item(FN_WDG, c));

    // Random phases with different idling
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 74; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 74; end
        3: begin send_idle_pct = 15; recv_stall_pct = 15; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int n = 0; n < 320; n++) begin
        for (int i = 0; i < 7; i++) c[i] = pick_component();
        pending_items.push_back(pack_item(($urandom_range(0, 19) == 0) ?
          4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8)), c));
      end
      // Long receiver hold-off while the sender keeps offering
      if (ph == 4) hold_cycles <= 300;
      while (pending_items.size() != 0 || s_tvalid) @(posedge clk);
      while (expected_results.size() != 0) @(posedge clk);
    end
    repeat (LATENCY + 5) @(posedge clk);
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    if (errors == 0) begin
      $display("vec3_fixed_point_alu_unit verification clean");
    end else begin
      $display("vec3_fixed_point_alu_unit verification failed");
    end
    $finish;
  end

  // Timeout
  initial begin
    #3000000;
    $display("vec3_fixed_point_alu_unit verification failed");
    $finish;
  end
endmodule
